// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks on aclk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// ----- sv/bdfa_pkg.sv -----
// ----------------------------------------------------------------------------
// bdfa_pkg
// Types and constants shared by the byte-stream DFA blocks.
// ----------------------------------------------------------------------------
package bdfa_pkg;

    localparam int MAX_STATES     = 64;
    localparam int ALPHABET_SIZE  = 256;
    localparam int MAX_RECORD_LEN = 4095;

    localparam int STATE_W   = 6;
    localparam int BYTE_W    = 8;
    localparam int REC_W     = 12;
    localparam int MEM_DEPTH = MAX_STATES * ALPHABET_SIZE;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    typedef enum logic [2:0] {
        ACT_WRITE_ENTRY  = 3'd0,
        ACT_SET_STATE    = 3'd1,
        ACT_PARSE_BYTE   = 3'd2,
        ACT_START_RECORD = 3'd3,
        ACT_STOP_RECORD  = 3'd4
    } bdfa_action_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_TRANS = 2'd1,
        STAT_IGNORED  = 2'd2
    } bdfa_status_t;

    typedef struct packed {
        logic [2:0]         action;
        logic [STATE_W-1:0] state_index;
        logic [BYTE_W-1:0]  input_byte;
        logic [STATE_W-1:0] dest_state;
        logic               dest_is_error;
        logic [REC_W-1:0]   record_length;
        logic               chunk_last;
    } bdfa_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [STATE_W-1:0] previous_state;
        logic [STATE_W-1:0] current_state_out;
        logic               state_changed;
        logic               record_valid;
        logic [BYTE_W-1:0]  record_byte;
        logic               record_trim;
        logic               chunk_end;
    } bdfa_out_t;

    // One transition memory entry
    typedef struct packed {
        logic               err;
        logic [STATE_W-1:0] dest;
    } bdfa_entry_t;

    localparam bdfa_entry_t ENTRY_ERROR = '{err: 1'b1, dest: '0};

    // Handshake control from the top level
    typedef struct packed {
        logic load;     // word accepted this cycle
        logic advance;  // execute stage moves into the result register
    } bdfa_ctrl_t;

endpackage

// ----- sv/table_driven_byte_dfa_unit.sv -----
// ----------------------------------------------------------------------------
// table_driven_byte_dfa_unit
// Byte-stream DFA with a transition memory indexed by state and byte.
//
//   channel  direction  payload     handshake
//   s_       in         bdfa_in_t   s_valid / s_ready
//   m_       out        bdfa_out_t  m_valid / m_ready
//
// One word per cycle while the m_ side is not stalled; a result passes through
// the execute stage and the result register. The rate is set by the path from
// the memory read data through the next state to the next read address.
// After reset a clearing sweep over the 16384 entries marks every entry as no
// transition; s_ready stays low until it ends.
// A stalled m_ side holds one result and one word in the execute stage.
// ----------------------------------------------------------------------------
module table_driven_byte_dfa_unit import bdfa_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  bdfa_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output bdfa_out_t m_data
);

`include "assert_macros.svh"

    bdfa_ctrl_t         ctrl;
    bdfa_entry_t        rd_entry;
    logic               clearing;
    logic               core_busy;
    logic [STATE_W-1:0] state_fwd;
    bdfa_out_t          core_result;
    bdfa_out_t          m_data_reg;
    logic               m_valid_reg;

    always_comb begin
        ctrl.advance = core_busy && (!m_valid_reg || m_ready);
        s_ready      = !clearing && (!core_busy || ctrl.advance);
        ctrl.load    = s_valid && s_ready;
    end

    bdfa_trans_mem u_mem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .s_word    (s_data),
        .state_fwd (state_fwd),
        .rd_entry  (rd_entry),
        .clearing  (clearing)
    );

    bdfa_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .s_word    (s_data),
        .rd_entry  (rd_entry),
        .busy      (core_busy),
        .state_fwd (state_fwd),
        .result    (core_result)
    );

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            m_data_reg <= core_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ASSERT_SAME(a_no_accept_while_clearing, clearing, !s_ready)
    `ASSERT_SAME(a_hold_when_full, core_busy && m_valid && !m_ready, !s_ready)
    `ASSERT_SAME(a_ignored_keeps_state, m_valid && (m_data.status == STAT_IGNORED), (m_data.previous_state == m_data.current_state_out) && !m_data.record_valid)
    `ASSERT_SAME(a_changed_means_moved, m_valid && m_data.state_changed, m_data.previous_state != m_data.current_state_out)
    `ASSERT_NEXT(a_advance_fills_output, ctrl.advance, m_valid)

endmodule

// ----- sv/bdfa_trans_mem.sv -----
// ----------------------------------------------------------------------------
// bdfa_trans_mem
// Transition memory: one write and one registered read per cycle, with a
// clearing sweep after reset that marks every entry as no transition.
// ----------------------------------------------------------------------------
module bdfa_trans_mem import bdfa_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  bdfa_ctrl_t         ctrl,
    input  bdfa_in_t           s_word,
    input  logic [STATE_W-1:0] state_fwd,
    output bdfa_entry_t        rd_entry,
    output logic               clearing
);

    bdfa_entry_t        mem [MEM_DEPTH];
    bdfa_entry_t        rd_entry_reg;
    logic [ADDR_W-1:0]  clear_addr_reg;
    logic [ADDR_W-1:0]  clear_addr_next;
    logic               clearing_reg;
    logic               clearing_next;

    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    bdfa_entry_t        wr_data;
    logic [ADDR_W-1:0]  rd_addr;
    logic               idx_ok;
    logic               dest_ok;

    always_comb begin
        idx_ok  = 32'(s_word.state_index) < MAX_STATES;
        dest_ok = 32'(s_word.dest_state) < MAX_STATES;
        rd_addr = {state_fwd, s_word.input_byte};
        if (clearing_reg) begin
            wr_en   = 1'b1;
            wr_addr = clear_addr_reg;
            wr_data = ENTRY_ERROR;
        end else begin
            wr_en   = ctrl.load && (s_word.action == ACT_WRITE_ENTRY) && idx_ok;
            wr_addr = {s_word.state_index, s_word.input_byte};
            if (s_word.dest_is_error || !dest_ok) begin
                wr_data = ENTRY_ERROR;
            end else begin
                wr_data = '{err: 1'b0, dest: s_word.dest_state};
            end
        end
        clear_addr_next = clear_addr_reg + ADDR_W'(1);
        clearing_next   = clearing_reg && (clear_addr_reg != ADDR_W'(MEM_DEPTH - 1));
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        // A write and a read come from the same word and may hit one address; the read then gets the old entry
        if (ctrl.load) begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg   <= 1'b1;
            clear_addr_reg <= '0;
        end else if (clearing_reg) begin
            clearing_reg   <= clearing_next;
            clear_addr_reg <= clear_addr_next;
        end
    end

    assign rd_entry = rd_entry_reg;
    assign clearing = clearing_reg;

endmodule

// ----- sv/bdfa_core.sv -----
// ----------------------------------------------------------------------------
// bdfa_core
// Execute stage: holds the accepted word, applies its action to the DFA and
// recording state, and forwards the resulting state to the memory address.
// ----------------------------------------------------------------------------
module bdfa_core import bdfa_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  bdfa_ctrl_t         ctrl,
    input  bdfa_in_t           s_word,
    input  bdfa_entry_t        rd_entry,
    output logic               busy,
    output logic [STATE_W-1:0] state_fwd,
    output bdfa_out_t          result
);

    bdfa_in_t           item_reg;
    logic               item_valid_reg;
    logic [STATE_W-1:0] cur_state_reg,   cur_state_next;
    logic               err_latched_reg, err_latched_next;
    logic [BYTE_W-1:0]  last_byte_reg,   last_byte_next;
    logic [REC_W-1:0]   rec_remain_reg,  rec_remain_next;
    logic [REC_W-1:0]   rec_count_reg,   rec_count_next;
    logic [REC_W-1:0]   rec_len_clamped;

    always_comb begin
        cur_state_next   = cur_state_reg;
        err_latched_next = err_latched_reg;
        last_byte_next   = last_byte_reg;
        rec_remain_next  = rec_remain_reg;
        rec_count_next   = rec_count_reg;
        rec_len_clamped  = (item_reg.record_length > REC_W'(MAX_RECORD_LEN)) ?
                           REC_W'(MAX_RECORD_LEN) : item_reg.record_length;
        result                = '0;
        result.status         = STAT_OK;
        result.previous_state = cur_state_reg;

        case (item_reg.action)
            ACT_WRITE_ENTRY: begin
                // memory write already done at accept
            end
            ACT_SET_STATE: begin
                if (32'(item_reg.state_index) < MAX_STATES) begin
                    cur_state_next   = item_reg.state_index;
                    err_latched_next = 1'b0;
                end
            end
            ACT_PARSE_BYTE: begin
                result.chunk_end = item_reg.chunk_last;
                if (err_latched_reg) begin
                    result.status = STAT_IGNORED;
                end else begin
                    last_byte_next = item_reg.input_byte;
                    if (rd_entry.err) begin
                        result.status    = STAT_NO_TRANS;
                        err_latched_next = 1'b1;
                    end else begin
                        if (rec_remain_reg != '0) begin
                            result.record_valid = 1'b1;
                            result.record_byte  = item_reg.input_byte;
                            rec_remain_next     = rec_remain_reg - REC_W'(1);
                            rec_count_next      = rec_count_reg + REC_W'(1);
                        end
                        result.state_changed = rd_entry.dest != cur_state_reg;
                        cur_state_next       = rd_entry.dest;
                    end
                end
            end
            ACT_START_RECORD: begin
                rec_remain_next = rec_len_clamped;
                rec_count_next  = '0;
                // capture the byte already seen
                if (rec_len_clamped != '0) begin
                    result.record_valid = 1'b1;
                    result.record_byte  = last_byte_reg;
                    rec_remain_next     = rec_len_clamped - REC_W'(1);
                    rec_count_next      = REC_W'(1);
                end
            end
            ACT_STOP_RECORD: begin
                result.record_trim = rec_count_reg != '0;
                rec_remain_next    = '0;
                rec_count_next     = '0;
            end
            default: begin
            end
        endcase

        result.current_state_out = cur_state_next;
        state_fwd = ctrl.advance ? cur_state_next : cur_state_reg;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            item_reg <= s_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg  <= 1'b0;
            cur_state_reg   <= '0;
            err_latched_reg <= 1'b0;
            last_byte_reg   <= '0;
            rec_remain_reg  <= '0;
            rec_count_reg   <= '0;
        end else begin
            if (ctrl.load) begin
                item_valid_reg <= 1'b1;
            end else if (ctrl.advance) begin
                item_valid_reg <= 1'b0;
            end
            if (ctrl.advance) begin
                cur_state_reg   <= cur_state_next;
                err_latched_reg <= err_latched_next;
                last_byte_reg   <= last_byte_next;
                rec_remain_reg  <= rec_remain_next;
                rec_count_reg   <= rec_count_next;
            end
        end
    end

    assign busy = item_valid_reg;

endmodule
